// ===== design/l3h_pkg.sv =====
// shared types, constants and mixing rounds for the lookup3 string hash
// no dependencies; imported by l3h_tail and lookup3_string_hash
`default_nettype none

package l3h_pkg;

   localparam logic [31:0] HASH_INIT  = 32'hDEADBEEF;
   localparam logic [3:0]  BLOCK_FULL = 4'd12;

   typedef enum logic [1:0] {
      LANE_A = 2'd0,
      LANE_B = 2'd1,
      LANE_C = 2'd2
   } lane_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
   } words_type;

   // one finished string on its way through the tail pipeline
   typedef struct packed {
      logic      direct;
      logic      mixed;
      words_type base;
      words_type acc;
   } tail_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int k);
      rotl = (x << k) | (x >> (32 - k));
   endfunction

   function automatic words_type add_words(input words_type x, input words_type y);
      words_type r;
      r.a = x.a + y.a;
      r.b = x.b + y.b;
      r.c = x.c + y.c;
      add_words = r;
   endfunction

   // block mix, first three lines
   function automatic words_type mix_lo(input words_type w);
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      a = w.a;
      b = w.b;
      c = w.c;
      a = a - c; a = a ^ rotl(c, 4);  c = c + b;
      b = b - a; b = b ^ rotl(a, 6);  a = a + c;
      c = c - b; c = c ^ rotl(b, 8);  b = b + a;
      mix_lo = '{a: a, b: b, c: c};
   endfunction

   // block mix, last three lines
   function automatic words_type mix_hi(input words_type w);
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      a = w.a;
      b = w.b;
      c = w.c;
      a = a - c; a = a ^ rotl(c, 16); c = c + b;
      b = b - a; b = b ^ rotl(a, 19); a = a + c;
      c = c - b; c = c ^ rotl(b, 4);  b = b + a;
      mix_hi = '{a: a, b: b, c: c};
   endfunction

   // final mix, first four lines
   function automatic words_type fin_lo(input words_type w);
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      a = w.a;
      b = w.b;
      c = w.c;
      c = c ^ b; c = c - rotl(b, 14);
      a = a ^ c; a = a - rotl(c, 11);
      b = b ^ a; b = b - rotl(a, 25);
      c = c ^ b; c = c - rotl(b, 16);
      fin_lo = '{a: a, b: b, c: c};
   endfunction

   // final mix, last three lines
   function automatic words_type fin_hi(input words_type w);
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      a = w.a;
      b = w.b;
      c = w.c;
      a = a ^ c; a = a - rotl(c, 4);
      b = b ^ a; b = b - rotl(a, 14);
      c = c ^ b; c = c - rotl(b, 24);
      fin_hi = '{a: a, b: b, c: c};
   endfunction

endpackage

`default_nettype wire

// ===== design/l3h_tail.sv =====
// tail pipeline: pending block mix, accumulator fold-in and final mix
// depends on l3h_pkg
`default_nettype none

module l3h_tail (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_stall,
   input  wire l3h_pkg::tail_type   in_item,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [63:0]              rsp_hash_value
);
   import l3h_pkg::*;

   tail_type    s0_ff, s1_ff, s2_ff;
   tail_type    s1_in, s2_in;
   logic        dir3_ff;
   logic [31:0] dval3_ff;
   words_type   fin3_ff, fin3_in;
   words_type   fin_out;
   words_type   folded;
   logic [63:0] hash_ff, hash_in;
   logic        v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic        adv0, adv1, adv2, adv3, adv4;

   // a stage moves on when the next one is empty or moving too
   assign adv4 = !v4_ff || !rsp_stall;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign adv0 = !v0_ff || adv1;
   assign in_stall = !adv0;

   always_comb begin
      s1_in      = s0_ff;
      s1_in.base = mix_lo(s0_ff.base);
      s2_in      = s1_ff;
      s2_in.base = mix_hi(s1_ff.base);
      folded     = s2_ff.mixed ? add_words(s2_ff.base, s2_ff.acc) : s2_ff.acc;
      fin3_in    = fin_lo(folded);
      fin_out    = fin_hi(fin3_ff);
      if (dir3_ff) begin
         hash_in = {dval3_ff, 32'd0};
      end else begin
         hash_in = {fin_out.b, fin_out.c};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv0) v0_ff <= in_valid;
         if (adv1) v1_ff <= v0_ff;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv0) s0_ff <= in_item;
      if (adv1) s1_ff <= s1_in;
      if (adv2) s2_ff <= s2_in;
      if (adv3) begin
         dir3_ff  <= s2_ff.direct;
         dval3_ff <= s2_ff.acc.a;
         fin3_ff  <= fin3_in;
      end
      if (adv4) hash_ff <= hash_in;
   end

   assign rsp_valid      = v4_ff;
   assign rsp_hash_value = hash_ff;

endmodule

`default_nettype wire

// ===== design/lookup3_string_hash.sv =====
// top level of the lookup3 (hashlittle2) byte string hash
// depends on l3h_pkg and l3h_tail
//
// usage
//   req channel: one byte per request; a request with req_first_item high
//   starts a new string and loads req_string_length (its byte is the first
//   byte of the string, or ignored when the length is zero). bytes with no
//   string in progress are taken and dropped
//   rsp channel: one 64-bit hash per finished string (word b high, word c low),
//   in the order the strings ended; an empty string gets its hash from
//   its one request, the start value in the high half
//   throughput: one request per clock, sustained while rsp_stall does not back up
//   the tail, for any string lengths; the per-byte path is one accumulate add,
//   and the block mix runs in a two-stage unit that finishes before the next block fills
//   path: the hash of the last byte goes through the input, two block mix,
//   fold-in and output stages, in that order, to the rsp ports
//   stall: rsp_stall holds the output register; the tail stages keep
//   filling, and req_stall rises only when all of them are occupied
//   reset: synchronous, clears the string state and empties the pipeline
`default_nettype none

module lookup3_string_hash (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_first_item,
   input  wire logic [15:0] req_string_length,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_hash_value
);
   import l3h_pkg::*;

   // string state: x holds the last full block before its mix, acc the
   // bytes added since (or the start words while no block has been mixed)
   words_type   x_ff, x_in;
   words_type   acc_ff, acc_in;
   logic        mixed_ff, mixed_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [3:0]  block_pos_ff, block_pos_in;

   // block mix unit, free running on x
   words_type   mix1_ff, mix2_ff;

   logic        req_accept;
   logic [31:0] init_word;
   words_type   cur_acc, acc_base;
   logic        cur_mixed;
   logic [15:0] cur_left;
   logic [3:0]  cur_pos, pos_eff;
   logic        live, empty_str, boundary;
   logic [31:0] byte_word;
   lane_type    lane;
   logic        tail_valid, tail_stall;
   tail_type    tail_item;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = tail_stall;

   always_comb begin
      init_word = HASH_INIT + {16'd0, req_string_length};
      if (req_first_item) begin
         cur_acc   = '{a: init_word, b: init_word, c: init_word};
         cur_mixed = 1'b0;
         cur_left  = req_string_length;
         cur_pos   = 4'd0;
      end else begin
         cur_acc   = acc_ff;
         cur_mixed = mixed_ff;
         cur_left  = bytes_left_ff;
         cur_pos   = block_pos_ff;
      end
      live      = req_first_item || (bytes_left_ff != 16'd0);
      empty_str = req_first_item && (req_string_length == 16'd0);
      boundary  = (cur_pos == BLOCK_FULL);

      // a full block with more to come: fold the mixed block into x and
      // restart the accumulator
      if (boundary) begin
         x_in     = cur_mixed ? add_words(mix2_ff, cur_acc) : cur_acc;
         acc_base = '0;
         pos_eff  = 4'd0;
      end else begin
         x_in     = x_ff;
         acc_base = cur_acc;
         pos_eff  = cur_pos;
      end

      byte_word = {24'd0, req_data_byte} << {pos_eff[1:0], 3'b000};
      lane      = lane_type'(pos_eff[3:2]);
      acc_in    = acc_base;
      case (lane)
         LANE_A:  acc_in.a = acc_base.a + byte_word;
         LANE_B:  acc_in.b = acc_base.b + byte_word;
         default: acc_in.c = acc_base.c + byte_word;
      endcase

      mixed_in      = cur_mixed || boundary;
      block_pos_in  = pos_eff + 4'd1;
      bytes_left_in = cur_left - 16'd1;

      tail_valid       = req_accept && (empty_str || (live && bytes_left_in == 16'd0));
      tail_item.direct = empty_str;
      tail_item.mixed  = mixed_in;
      tail_item.base   = x_in;
      tail_item.acc    = empty_str ? cur_acc : acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= 16'd0;
         block_pos_ff  <= 4'd0;
         mixed_ff      <= 1'b0;
      end else if (req_accept && live) begin
         if (empty_str) begin
            bytes_left_ff <= 16'd0;
            block_pos_ff  <= 4'd0;
            mixed_ff      <= 1'b0;
         end else begin
            bytes_left_ff <= bytes_left_in;
            block_pos_ff  <= block_pos_in;
            mixed_ff      <= mixed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && live && !empty_str) begin
         x_ff   <= x_in;
         acc_ff <= acc_in;
      end
      mix1_ff <= mix_lo(x_ff);
      mix2_ff <= mix_hi(mix1_ff);
   end

   l3h_tail u_tail (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (tail_valid),
      .in_stall       (tail_stall),
      .in_item        (tail_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

   // a one-byte string finishes on its first request
   a_single_byte_done: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_first_item && req_string_length == 16'd1
      |=> bytes_left_ff == 16'd0)
      else $error("string of one byte left bytes pending");

   // a string in progress always has at least one byte in its block
   a_pos_nonzero: assert property (@(posedge clock) disable iff (reset)
      bytes_left_ff != 16'd0 |-> block_pos_ff != 4'd0 && block_pos_ff <= BLOCK_FULL)
      else $error("block position out of step with bytes left");

   // requests are held back only by a stalled, waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with the output free");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for lookup3_string_hash, the hashlittle2 byte string hash
// depends on l3h_pkg (HASH_INIT, lane_type) and on the lookup3_string_hash design
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import l3h_pkg::*;

   // bytes of a string: random content, or all zero / all ones for the corners
   typedef enum int {
      BYTES_RANDOM,
      BYTES_ZERO,
      BYTES_ONES
   } byte_fill_type;

   localparam int RESET_CYCLES  = 10;
   localparam int RANDOM_ITEMS  = 400;
   localparam int LONGEST       = 65535;
   localparam int LONG_RUN      = 120;
   // ~560 requests, each with the longest idle gap and rsp stall, several times over
   localparam int CYCLE_LIMIT   = 120000;
   localparam int DRAIN_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 12;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_first_item = 1'b0;
   logic [15:0] req_string_length = 16'h0000;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_hash_value;

   lookup3_string_hash u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_first_item    (req_first_item),
      .req_string_length (req_string_length),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hash_value    (rsp_hash_value)
   );

   // predicted hash words and string progress
   logic [31:0] acc_a = '0;
   logic [31:0] acc_b = '0;
   logic [31:0] acc_c = '0;
   logic [15:0] bytes_due = '0;
   logic [3:0]  block_fill = '0;

   logic [63:0] expected_hashes[$];
   int          failures = 0;
   int          bytes_taken = 0;   // requests that add a byte to a string
   int          cycle_count = 0;
   bit          no_idle = 1'b0;    // both sides run flat out while set
   int          hold_left = 0;     // cycles of rsp_stall still to go

   initial begin
      forever #6 clock = ~clock;
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top failed");
      $finish;
   end

   function automatic logic [31:0] rol32(input logic [31:0] x, input int k);
      return (x << k) | (x >> (32 - k));
   endfunction

   // mix between two full 12-byte blocks
   function automatic void mix_block();
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      a = acc_a;
      b = acc_b;
      c = acc_c;
      a -= c; a ^= rol32(c, 4);  c += b;
      b -= a; b ^= rol32(a, 6);  a += c;
      c -= b; c ^= rol32(b, 8);  b += a;
      a -= c; a ^= rol32(c, 16); c += b;
      b -= a; b ^= rol32(a, 19); a += c;
      c -= b; c ^= rol32(b, 4);  b += a;
      acc_a = a;
      acc_b = b;
      acc_c = c;
   endfunction

   // closing avalanche after the last byte
   function automatic void mix_final();
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      a = acc_a;
      b = acc_b;
      c = acc_c;
      c ^= b; c -= rol32(b, 14);
      a ^= c; a -= rol32(c, 11);
      b ^= a; b -= rol32(a, 25);
      c ^= b; c -= rol32(b, 16);
      a ^= c; a -= rol32(c, 4);
      b ^= a; b -= rol32(a, 14);
      c ^= b; c -= rol32(b, 24);
      acc_a = a;
      acc_b = b;
      acc_c = c;
   endfunction

   // update the predicted state for one accepted request, queue any hash it finishes
   function automatic void predict_hash(input logic [7:0] data, input logic first,
                                        input logic [15:0] len);
      logic [31:0] start;
      logic [31:0] lane_add;
      if (first) begin
         start      = HASH_INIT + {16'h0000, len};
         acc_a      = start;
         acc_b      = start;
         acc_c      = start;
         bytes_due  = len;
         block_fill = '0;
         if (len == 0) begin
            // empty string: start value high, zero low
            expected_hashes.push_back({start, 32'h0000_0000});
            return;
         end
      end else if (bytes_due == 0) begin
         // stray byte, nothing in progress
         return;
      end
      bytes_taken++;
      // a full block followed by more bytes gets mixed first
      if (block_fill == 4'd12) begin
         mix_block();
         block_fill = '0;
      end
      lane_add = {24'h000000, data} << {block_fill[1:0], 3'b000};
      case (lane_type'(block_fill[3:2]))
         LANE_A:  acc_a += lane_add;
         LANE_B:  acc_b += lane_add;
         default: acc_c += lane_add;
      endcase
      block_fill++;
      bytes_due--;
      if (bytes_due == 0) begin
         mix_final();
         expected_hashes.push_back({acc_b, acc_c});
      end
   endfunction

   // idle cycles before a request or stall cycles after a hash, mostly short
   function automatic int draw_wait();
      if (no_idle) return 0;
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return $urandom_range(0, 2);
         default: return $urandom_range(0, 17);
      endcase
   endfunction

   function automatic logic [7:0] draw_byte(input byte_fill_type fill);
      case (fill)
         BYTES_ZERO: return 8'h00;
         BYTES_ONES: return 8'hFF;
         default: begin
            case ($urandom_range(0, 7))
               0:       return 8'h00;
               1:       return 8'hFF;
               default: return 8'($urandom_range(0, 255));
            endcase
         end
      endcase
   endfunction

   // one request on the req channel; valid stays high if the next one follows at once
   task automatic send_request(input logic [7:0] data, input logic first,
                               input logic [15:0] len);
      int gap;
      gap = draw_wait();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= data;
      req_first_item    <= first;
      req_string_length <= len;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_hash(data, first, len);
   endtask

   // first request carries the length; count may stop short of len to abandon it
   task automatic send_string(input int len, input int count, input byte_fill_type fill);
      for (int i = 0; i < count; i++) begin
         if (i == 0) send_request(draw_byte(fill), 1'b1, 16'(len));
         else        send_request(draw_byte(fill), 1'b0, 16'($urandom_range(0, 65535)));
      end
      if (count == 0) send_request(draw_byte(fill), 1'b1, 16'(len));
   endtask

   // hash checker and rsp_stall generator
   always @(posedge clock) begin : hash_check
      logic [63:0] want;
      int          stall_len;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (expected_hashes.size() == 0) begin
            $error("hash_value: expected none, actual %h", rsp_hash_value);
            failures++;
         end else begin
            want = expected_hashes.pop_front();
            if (rsp_hash_value !== want) begin
               $error("hash_value: expected %h, actual %h", want, rsp_hash_value);
               failures++;
            end
         end
         stall_len = draw_wait();
         hold_left <= stall_len;
         rsp_stall <= (stall_len != 0);
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         if (hold_left == 1) rsp_stall <= 1'b0;
      end
   end

   // a byte with no string in progress, right after reset
   task automatic test_stray_bytes();
      send_request(8'hFF, 1'b0, 16'hFFFF);
   endtask

   task automatic test_empty_string();
      send_request(8'hFF, 1'b1, 16'h0000);
   endtask

   // single bytes and a block boundary with one byte past it
   task automatic test_block_edges();
      send_string(1, 1, BYTES_ONES);
      send_string(1, 1, BYTES_ZERO);
      send_string(13, 13, BYTES_ONES);
   endtask

   // a new first request abandons the string in progress
   task automatic test_restart();
      send_string(LONGEST, 2, BYTES_RANDOM);
      send_string(3, 3, BYTES_ZERO);
   endtask

   // a string of many blocks, sent flat out
   task automatic test_long_string();
      no_idle = 1'b1;
      send_string(LONG_RUN, LONG_RUN, BYTES_RANDOM);
      no_idle = 1'b0;
   endtask

   task automatic test_random_strings();
      int target;
      int len;
      target = bytes_taken + RANDOM_ITEMS;
      while (bytes_taken < target) begin
         // some stretches with no idling on either side
         no_idle = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 9))
            0: begin
               // abandoned part of a long string
               len = $urandom_range(2, 65535);
               send_string(len, $urandom_range(1, (len - 1 < 15) ? len - 1 : 15),
                           BYTES_RANDOM);
            end
            1: begin
               // complete string, then bytes nobody asked for
               len = $urandom_range(0, 13);
               send_string(len, len, BYTES_RANDOM);
               repeat ($urandom_range(1, 2))
                  send_request(draw_byte(BYTES_RANDOM), 1'b0, 16'($urandom_range(0, 65535)));
            end
            2, 3, 4: begin
               len = $urandom_range(0, 13);
               send_string(len, len, BYTES_RANDOM);
            end
            5, 6: begin
               len = $urandom_range(14, 40);
               send_string(len, len, BYTES_RANDOM);
            end
            default: begin
               // on or just past a block boundary
               len = 12 * $urandom_range(1, 3) + $urandom_range(0, 1);
               send_string(len, len, BYTES_RANDOM);
            end
         endcase
      end
      no_idle = 1'b0;
   endtask

   // let every hash come out, then keep watching for anything unexpected
   task automatic drain_hashes();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (expected_hashes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_hashes.size() != 0) begin
         $error("hash_value: expected %h, actual none", expected_hashes[0]);
         failures++;
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_stray_bytes();
      test_empty_string();
      test_block_edges();
      test_restart();
      test_long_string();
      test_random_strings();
      drain_hashes();
      if (failures == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/l3h_pkg.sv
design/l3h_tail.sv
design/lookup3_string_hash.sv
tb/tb_top.sv
